// ===== rtl/fpmt_pkg.sv =====
`timescale 1ns / 1ps

package fpmt_pkg;

    // Field widths of the command and result items
    localparam int POS_W  = 18;
    localparam int DATA_W = 48;

    // Default sizing of the tree
    localparam int DEF_MAX_POSITIONS = 131072;
    localparam int DEF_VALUE_BITS    = 48;

    typedef enum logic
    {
        CMD_RAISE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                cmd;
        logic [POS_W-1:0]    position;
        logic [DATA_W-1:0]   value;
    } item_t;

    typedef struct packed
    {
        logic [DATA_W-1:0]   prefix_max;
        logic                bad_position;
    } result_t;

    // Start request from the front end to the tree walker
    typedef struct packed
    {
        logic go;
        cmd_t cmd;
    } eng_ctrl_t;

    // Walker status back to the front end
    typedef struct packed
    {
        logic busy;
        logic fin;
    } eng_stat_t;

    // Width of an index counter: holds the position field, the tree size
    // and one carry bit for the upward step
    function automatic int idx_width(input int max_positions);
        int w;
        w = $clog2(max_positions + 1);
        if (w < POS_W)
        begin
            w = POS_W;
        end
        return w + 1;
    endfunction

endpackage

// ===== rtl/fpmt_engine.sv =====
`timescale 1ns / 1ps

module fpmt_engine #(
    parameter int MAX_POSITIONS = fpmt_pkg::DEF_MAX_POSITIONS,
    parameter int VALUE_BITS    = fpmt_pkg::DEF_VALUE_BITS,
    parameter int CW            = fpmt_pkg::idx_width(MAX_POSITIONS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpmt_pkg::eng_ctrl_t   ctrl,
    input  logic [CW-1:0]         start_pos,
    input  logic [VALUE_BITS-1:0] start_val,
    input  logic [CW-1:0]         size,
    output fpmt_pkg::eng_stat_t   stat,
    output logic [VALUE_BITS-1:0] best
);
    import fpmt_pkg::*;

    localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

    typedef enum logic [1:0]
    {
        S_CLEAR,
        S_IDLE,
        S_WALK
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [CW-1:0]         p_reg;
    logic [VALUE_BITS-1:0] val_reg;
    cmd_t                  cmd_reg;
    logic [VALUE_BITS-1:0] best_reg;
    logic                  pend_vld_reg;
    logic [AW-1:0]         pend_addr_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;

    logic [VALUE_BITS-1:0] mem [MAX_POSITIONS];

    logic                  issue;
    logic [CW-1:0]         low_bit;
    logic [CW-1:0]         p_minus_one;
    logic [AW-1:0]         rd_addr;
    logic                  fin;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [VALUE_BITS-1:0] mem_wd;

    // Step control: visit the node at p while it is inside the tree
    always_comb
    begin
        issue       = (p_reg != '0) && ((cmd_reg == CMD_QUERY) || (p_reg <= size));
        low_bit     = p_reg & (~p_reg + CW'(1));
        p_minus_one = p_reg - CW'(1);
        rd_addr     = p_minus_one[AW-1:0];
        fin         = (state_reg == S_WALK) && !issue && !pend_vld_reg;
    end

    // Write port: zero sweep after reset, raise on a lower node during an update
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = pend_addr_reg;
        mem_wd = val_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = '0;
            end
            S_WALK:
            begin
                mem_we = pend_vld_reg && (cmd_reg == CMD_RAISE) && (rd_data_reg < val_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Node store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer: clear sweep, then one node read per cycle, the compare in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            p_reg         <= '0;
            val_reg       <= '0;
            cmd_reg       <= CMD_RAISE;
            best_reg      <= '0;
            pend_vld_reg  <= 1'b0;
            pend_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (ctrl.go)
                    begin
                        p_reg        <= start_pos;
                        val_reg      <= start_val;
                        cmd_reg      <= ctrl.cmd;
                        best_reg     <= '0;
                        pend_vld_reg <= 1'b0;
                        state_reg    <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    pend_vld_reg  <= issue;
                    pend_addr_reg <= rd_addr;
                    // advance up by the lowest set bit on update, down on query
                    if (issue)
                    begin
                        if (cmd_reg == CMD_RAISE)
                        begin
                            p_reg <= p_reg + low_bit;
                        end
                        else
                        begin
                            p_reg <= p_reg - low_bit;
                        end
                    end
                    if (pend_vld_reg && (cmd_reg == CMD_QUERY) && (rd_data_reg > best_reg))
                    begin
                        best_reg <= rd_data_reg;
                    end
                    if (fin)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.fin  = fin;
    assign best      = best_reg;

endmodule

// ===== rtl/fenwick_prefix_max_tree.sv =====
`timescale 1ns / 1ps

// Channel   Ports                    Handshake
// ------    ---------------------    ------------------------------------
// command   item (cmd/pos/value)     taken on a clock edge with start && !busy
// result    result (max/bad)         valid for the one cycle that done is high
// config    size_we, size_wdata      written on a clock edge with size_we high
//
// An update or query walks one tree node per cycle through the single-port
// read path of the node store, over at most 18 nodes at the full size.
// An update to a bad position is flagged on done in the cycle after it is
// taken. After reset the node store is swept to zero with busy high; size
// writes are taken at any time. done cannot be stalled.

module fenwick_prefix_max_tree #(
    parameter int MAX_POSITIONS = fpmt_pkg::DEF_MAX_POSITIONS,
    parameter int VALUE_BITS    = fpmt_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fpmt_pkg::item_t                item,
    output logic                           done,
    output fpmt_pkg::result_t              result,
    input  logic                           size_we,
    input  logic [fpmt_pkg::POS_W-1:0]     size_wdata
);
    import fpmt_pkg::*;

    localparam int CW = idx_width(MAX_POSITIONS);
    localparam int SW = $clog2(MAX_POSITIONS + 1);
    localparam int WIDE = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;

    logic [SW-1:0]         size_reg;
    logic                  done_reg;
    result_t               result_reg;

    eng_ctrl_t             eng_ctrl;
    eng_stat_t             eng_stat;
    logic [CW-1:0]         size_ext;
    logic [CW-1:0]         pos_ext;
    logic [CW-1:0]         wsize_ext;
    logic [CW-1:0]         start_pos;
    logic [WIDE-1:0]       in_val_wide;
    logic [WIDE-1:0]       best_wide;
    logic [VALUE_BITS-1:0] best;
    logic                  accept;
    logic                  bad_req;

    // Decode the command item
    always_comb
    begin
        size_ext    = CW'(size_reg);
        pos_ext     = CW'(item.position);
        wsize_ext   = CW'(size_wdata);
        in_val_wide = WIDE'(item.value);
        accept      = start && !busy;
        bad_req     = (item.cmd == CMD_RAISE) && ((pos_ext == '0) || (pos_ext > size_ext));
        start_pos   = pos_ext;
        if ((item.cmd == CMD_QUERY) && (pos_ext > size_ext))
        begin
            start_pos = size_ext;
        end
        eng_ctrl.go  = accept && !bad_req;
        eng_ctrl.cmd = item.cmd;
    end

    fpmt_engine #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .VALUE_BITS    (VALUE_BITS),
        .CW            (CW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (eng_ctrl),
        .start_pos (start_pos),
        .start_val (in_val_wide[VALUE_BITS-1:0]),
        .size      (size_ext),
        .stat      (eng_stat),
        .best      (best)
    );

    // Hold the size register, clamped into 1 .. MAX_POSITIONS
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SW'(MAX_POSITIONS);
        end
        else if (size_we)
        begin
            if (wsize_ext == '0)
            begin
                size_reg <= SW'(1);
            end
            else if (wsize_ext > CW'(MAX_POSITIONS))
            begin
                size_reg <= SW'(MAX_POSITIONS);
            end
            else
            begin
                size_reg <= wsize_ext[SW-1:0];
            end
        end
    end

    // Strobe the result: walk finished or bad update rejected
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= eng_stat.fin || (accept && bad_req);
        end
    end

    assign best_wide = WIDE'(best);

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (eng_stat.fin)
        begin
            result_reg.prefix_max   <= best_wide[DATA_W-1:0];
            result_reg.bad_position <= 1'b0;
        end
        else if (accept)
        begin
            result_reg.prefix_max   <= '0;
            result_reg.bad_position <= 1'b1;
        end
    end

    assign busy   = eng_stat.busy;
    assign done   = done_reg;
    assign result = result_reg;

    // A rejected update is flagged on the very next cycle
    a_bad_next: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && bad_req |=> done && result.bad_position)
        else $error("bad update not flagged on the next cycle");

    // A valid item starts a walk and holds off the next item
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !bad_req |=> busy && !done)
        else $error("walk did not start for a valid item");

    // A flagged result never carries a maximum
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.bad_position |-> result.prefix_max == '0)
        else $error("flagged result carries a nonzero maximum");

    // The walk only finishes while the front end is held off
    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.fin |-> busy && !(start && !busy))
        else $error("walk finished while an item could be taken");

endmodule
